### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked check, switched off while reset is held
`define OLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also runs through reset
`define OLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define OLE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hdl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// request and result word types, request kinds and status codes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ole_pkg;

    localparam int KIND_W   = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    // request kinds
    localparam logic [KIND_W-1:0] K_INS_FRONT  = 3'd0;
    localparam logic [KIND_W-1:0] K_INS_BACK   = 3'd1;
    localparam logic [KIND_W-1:0] K_DEL_VALUE  = 3'd2;
    localparam logic [KIND_W-1:0] K_DEL_POS    = 3'd3;
    localparam logic [KIND_W-1:0] K_FIND_VALUE = 3'd4;
    localparam logic [KIND_W-1:0] K_READ_POS   = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] answer;
        logic [STATUS_W-1:0]      status;
        logic [LEN_W-1:0]         length;
    } t_out_word;

endpackage

### hdl/ole_ram.sv
// ----------------------------------------------------------------------------
// ole_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ole_core.sv
// ----------------------------------------------------------------------------
// ole_core
// list sequencer: circular entry store, insert, scan/compact and read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ole_core import ole_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_stall,
    input  t_in_word  i_req,
    output logic      o_res_valid,
    input  logic      i_res_stall,
    output t_out_word o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [AW:0] DEPTH_X = (AW + 1)'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } t_state;

    // logical index to physical address, head plus offset wrapping at depth
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= DEPTH_X) begin
            s = s - DEPTH_X;
        end
        return s[AW-1:0];
    endfunction

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_pend, n_pend;
    logic                     r_hit, n_hit;
    logic [KIND_W-1:0]        r_kind, n_kind;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic [AW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_k, n_k;
    logic [CW-1:0]            r_keep, n_keep;
    logic [AW-1:0]            r_pk, n_pk;
    logic signed [DATA_W-1:0] r_ans, n_ans;
    logic [STATUS_W-1:0]      r_status, n_status;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic [PW-1:0] w_pos_x;
    logic [PW-1:0] w_cnt_x;
    logic          w_pos_bad;
    logic [AW-1:0] w_idx;
    logic [AW-1:0] w_head_dec;
    logic          w_full;

    ole_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign w_pos_x    = PW'(i_req.position);
    assign w_cnt_x    = PW'(r_count);
    assign w_pos_bad  = (w_pos_x == '0) || (w_pos_x > w_cnt_x);
    assign w_idx      = AW'(w_pos_x - PW'(1));
    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign w_full     = (r_count >= CW'(DEPTH));

    always_comb begin
        logic v_match;
        logic v_drop;

        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_pend    = r_pend;
        n_hit     = r_hit;
        n_kind    = r_kind;
        n_val     = r_val;
        n_idx     = r_idx;
        n_k       = r_k;
        n_keep    = r_keep;
        n_pk      = r_pk;
        n_ans     = r_ans;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        v_match   = 1'b0;
        v_drop    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind   = i_req.kind;
                    n_val    = i_req.value;
                    n_idx    = w_idx;
                    n_ans    = '0;
                    n_status = ST_OK;
                    n_hit    = 1'b0;
                    n_k      = '0;
                    n_keep   = '0;
                    n_pend   = 1'b0;
                    n_state  = S_DONE;
                    unique case (i_req.kind) inside
                        K_INS_FRONT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_head    = w_head_dec;
                                mem_we    = 1'b1;
                                mem_waddr = w_head_dec;
                                mem_wdata = i_req.value;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        K_INS_BACK: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = f_phys(r_head, AW'(r_count));
                                mem_wdata = i_req.value;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        K_DEL_VALUE, K_FIND_VALUE: begin
                            if (r_count == '0) begin
                                n_status = ST_MISSING;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        K_DEL_POS: begin
                            if (w_pos_bad) begin
                                n_status = ST_MISSING;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        K_READ_POS: begin
                            if (w_pos_bad) begin
                                n_status = ST_MISSING;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = f_phys(r_head, w_idx);
                                n_state   = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_ans   = mem_rdata;
                n_state = S_DONE;
            end
            S_SCAN: begin
                // issue side: one read per cycle in list order
                if (r_k < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = f_phys(r_head, r_k[AW-1:0]);
                    n_pend    = 1'b1;
                    n_pk      = r_k[AW-1:0];
                    n_k       = r_k + CW'(1);
                end else begin
                    n_pend = 1'b0;
                end
                // return side: keep index never passes the read index, so the
                // write always lands on an entry that was already read
                if (r_pend) begin
                    v_match = (mem_rdata == r_val);
                    if (r_kind == K_FIND_VALUE) begin
                        if (v_match && !r_hit) begin
                            n_hit = 1'b1;
                            n_ans = DATA_W'(r_pk) + DATA_W'(1);
                        end
                    end else begin
                        v_drop = (r_kind == K_DEL_VALUE) ? v_match : (r_pk == r_idx);
                        if (v_drop) begin
                            n_hit = 1'b1;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = f_phys(r_head, r_keep[AW-1:0]);
                            mem_wdata = mem_rdata;
                            n_keep    = r_keep + CW'(1);
                        end
                    end
                end
                // last entry handled this cycle
                if (r_k >= r_count) begin
                    n_state = S_DONE;
                    n_pend  = 1'b0;
                    if (r_kind != K_FIND_VALUE) begin
                        n_count = n_keep;
                    end
                    n_status = (n_hit || (r_kind == K_DEL_POS)) ? ST_OK : ST_MISSING;
                end
            end
            S_DONE: begin
                if (!i_res_stall) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_hit   <= n_hit;
        end
        r_kind   <= n_kind;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_keep   <= n_keep;
        r_pk     <= n_pk;
        r_ans    <= n_ans;
        r_status <= n_status;
    end

    assign o_req_stall  = (r_state != S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);

    always_comb begin
        o_res.answer = r_ans;
        o_res.status = r_status;
        o_res.length = LEN_W'(r_count);
    end

    `OLE_ASSERT(a_head_held, i_clk, i_rst_n, (r_state != S_IDLE) |=> $stable(r_head), "list head moved while busy")
    `OLE_ASSERT(a_scan_no_clash, i_clk, i_rst_n, (r_state == S_SCAN && mem_we && mem_re) |-> (mem_waddr != mem_raddr), "compaction write hit the entry being read")
    `OLE_ASSERT(a_keep_behind, i_clk, i_rst_n, r_pend |-> (r_keep <= CW'(r_pk)), "keep index ran ahead of read index")
    `OLE_ASSERT(a_full_flag, i_clk, i_rst_n, (r_state == S_DONE && r_status == ST_FULL) |-> (r_count == CW'(DEPTH)), "full reported on a list with room")

endmodule

### hdl/ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// bounded ordered list of signed 32-bit values held in one ram.
// request channel: i_in_valid / o_in_stall carry one request word (kind,
// value, position); result channel: o_out_valid / i_out_stall carry one
// result word (answer, status, length) per request, in request order.
// one request is worked at a time; o_in_stall is high from acceptance until
// its result has moved into the output register.
// inserts and unused kinds go straight to their result; read position
// reads one entry; delete value, delete position and find value scan
// the whole list; a request turned away on entry (empty list or bad
// position) goes straight to its result. a scan reads one entry per
// cycle through the ram read port while the compaction writes back
// through the single write port.
// the list is a circular buffer (head pointer plus count), so a front
// insert is a single write; deletes close the gap by compacting in place.
// a result moves from the done state into the output register; a new
// request is taken while that result still waits on a stalled receiver.
// reset (synchronous, active low) empties the list; ram contents are left
// as they are and never read before being written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_engine_top import ole_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // request channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in,
    // result channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out
);

    // core side of the output register
    logic      core_res_valid;
    logic      core_res_stall;
    t_out_word core_res;

    // output register
    logic      r_out_valid;
    t_out_word r_out;

    // sequencer and entry store
    ole_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_stall (o_in_stall),
        .i_req       (i_in),
        .o_res_valid (core_res_valid),
        .i_res_stall (core_res_stall),
        .o_res       (core_res)
    );

    // the core may hand over a word whenever the register is empty or
    // its current word leaves in this cycle
    assign core_res_stall = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res_valid && !core_res_stall) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        // payload holds while the receiver stalls
        if (core_res_valid && !core_res_stall) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
